[hw/rtl/bpu_pkg.sv]
// Shared types and constants for the BMP pixel unpacker.
// Used by bpu_front, bpu_queue, bpu_back and bmp_pixel_unpacker.
package bpu_pkg;

	localparam int unsigned MAX_WIDTH    = 4096;
	localparam int unsigned MAX_HEIGHT   = 4096;
	localparam int unsigned PAL_DEPTH    = 256;
	localparam int unsigned QUEUE_DEPTH  = 4;

	localparam logic [31:0] ALPHA_FORCE  = 32'hFF00_0000;
	localparam logic [31:0] KEY_BLACK    = 32'hFF00_0000;
	localparam logic [31:0] KEY_MAGENTA  = 32'hFFFF_00FF;

	// Input op codes
	localparam logic OP_PAL_WRITE = 1'b0;
	localparam logic OP_DATA      = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] REG_BPP    = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	// Kind of work handed from front to back
	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,  // palette write
		KIND_INDEX = 2'd1,  // one or more palette lookups
		KIND_RAW   = 2'd2   // one assembled raw pixel
	} kind_t;

	typedef struct packed {
		logic [5:0]  bits_per_pixel;
		logic [12:0] image_width;
		logic [12:0] image_height;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  byte_val;   // palette index on writes, packed indices on lookups
		logic [23:0] color;      // palette color on writes, raw pixel on raw
		logic [1:0]  dsel;       // log2 of depth for lookups (0..3 = 1,2,4,8)
		logic [3:0]  npix;       // pixels carried, 1..8
		logic        row_end;    // applies to the last pixel
		logic        image_end;  // applies to the last pixel
	} cmd_t;

	// Force alpha and apply the transparent color key
	function automatic logic [31:0] finish_pixel(input logic [23:0] rgb);
		logic [31:0] p;
		p = ALPHA_FORCE | {8'h00, rgb};
		if (p == KEY_BLACK || p == KEY_MAGENTA) begin
			p = 32'h0;
		end
		return p;
	endfunction

endpackage

[hw/rtl/bpu_front.sv]
// Front end of the BMP pixel unpacker: classifies items, tracks row and
// column position and assembles raw pixels. Depends on bpu_pkg.
module bpu_front (
	input  logic              clk,
	input  logic              arst_n,
	input  bpu_pkg::cfg_t     cfg,
	input  logic              accept,
	input  logic              op,
	input  logic [7:0]        palette_index,
	input  logic [23:0]       palette_color,
	input  logic [7:0]        data_byte,
	output logic              push,
	output bpu_pkg::cmd_t     cmd
);
	import bpu_pkg::*;

	logic [23:0] asm_q;
	logic [1:0]  bip_q;
	logic [12:0] col_q;
	logic [11:0] row_q;
	logic [14:0] rbc_q;

	logic        depth_ok;
	logic        is_sub;
	logic        is_multi;
	logic [1:0]  dsel;
	logic [2:0]  nbytes;
	logic [12:0] w;
	logic [12:0] h;
	logic [17:0] w18;
	logic [17:0] dw;
	logic [17:0] dw_up;
	logic [14:0] stride;
	logic        col_ok;
	logic [12:0] rem;
	logic [3:0]  per;
	logic [3:0]  n;
	logic [12:0] col_after;
	logic [12:0] row_inc;
	logic        row_end;
	logic        image_end;
	logic [23:0] asm_next;
	logic        pix_done;
	logic        emit;
	logic [14:0] rbc_inc;
	logic        data_go;

	// Decode the pixel depth
	always_comb begin
		depth_ok = 1'b1;
		is_sub   = 1'b0;
		is_multi = 1'b0;
		dsel     = 2'd3;
		nbytes   = 3'd1;
		w18      = {5'b0, w};
		dw       = w18;
		unique case (cfg.bits_per_pixel)
			6'd1: begin
				is_sub = 1'b1; dsel = 2'd0; dw = w18;
			end
			6'd2: begin
				is_sub = 1'b1; dsel = 2'd1; dw = w18 << 1;
			end
			6'd4: begin
				is_sub = 1'b1; dsel = 2'd2; dw = w18 << 2;
			end
			6'd8: begin
				dsel = 2'd3; dw = w18 << 3;
			end
			6'd16: begin
				is_multi = 1'b1; nbytes = 3'd2; dw = w18 << 4;
			end
			6'd24: begin
				is_multi = 1'b1; nbytes = 3'd3; dw = (w18 << 4) + (w18 << 3);
			end
			6'd32: begin
				is_multi = 1'b1; nbytes = 3'd4; dw = w18 << 5;
			end
			default: begin
				depth_ok = 1'b0;
			end
		endcase
	end

	// Saturate width and height, derive the padded row stride
	always_comb begin
		if (cfg.image_width == 13'd0) begin
			w = 13'd1;
		end else if (cfg.image_width > 13'(MAX_WIDTH)) begin
			w = 13'(MAX_WIDTH);
		end else begin
			w = cfg.image_width;
		end
		if (cfg.image_height == 13'd0) begin
			h = 13'd1;
		end else if (cfg.image_height > 13'(MAX_HEIGHT)) begin
			h = 13'(MAX_HEIGHT);
		end else begin
			h = cfg.image_height;
		end
		dw_up  = dw + 18'd31;
		stride = {dw_up[17:5], 2'b00};
	end

	// Work out how many pixels this byte yields and the assembled pixel
	always_comb begin
		col_ok = col_q < w;
		rem    = w - col_q;
		per    = 4'd8 >> dsel;
		if (is_sub) begin
			n = (rem >= {9'b0, per}) ? per : rem[3:0];
		end else begin
			n = 4'd1;
		end

		unique case (bip_q)
			2'd0:    asm_next = {16'b0, data_byte};
			2'd1:    asm_next = asm_q | {8'b0, data_byte, 8'b0};
			2'd2:    asm_next = asm_q | {data_byte, 16'b0};
			default: asm_next = asm_q;
		endcase
		pix_done = ({1'b0, bip_q} + 3'd1) >= nbytes;

		emit      = col_ok && (!is_multi || pix_done);
		col_after = col_q + {9'b0, n};
		row_inc   = {1'b0, row_q} + 13'd1;
		row_end   = col_after >= w;
		image_end = row_end && (row_inc >= h);
		rbc_inc   = rbc_q + 15'd1;
		data_go   = accept && (op == OP_DATA) && depth_ok;
	end

	// Build the command for the back end
	always_comb begin
		cmd.kind      = KIND_INDEX;
		cmd.byte_val  = data_byte;
		cmd.color     = asm_next;
		cmd.dsel      = dsel;
		cmd.npix      = n;
		cmd.row_end   = row_end;
		cmd.image_end = image_end;
		push          = 1'b0;
		if (op == OP_PAL_WRITE) begin
			cmd.kind     = KIND_WRITE;
			cmd.byte_val = palette_index;
			cmd.color    = palette_color;
			push         = accept;
		end else begin
			cmd.kind = is_multi ? KIND_RAW : KIND_INDEX;
			push     = data_go && emit;
		end
	end

	// Advance position counters and pixel assembly on each data item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asm_q <= '0;
			bip_q <= '0;
			col_q <= '0;
			row_q <= '0;
			rbc_q <= '0;
		end else if (data_go) begin
			if (is_multi && col_ok) begin
				asm_q <= asm_next;
			end
			if (rbc_inc >= stride) begin
				// Close the row: clear position, advance or wrap the row count
				rbc_q <= '0;
				col_q <= '0;
				bip_q <= '0;
				row_q <= (row_inc >= h) ? 12'd0 : row_inc[11:0];
			end else begin
				rbc_q <= rbc_inc;
				if (is_multi && col_ok) begin
					bip_q <= pix_done ? 2'd0 : bip_q + 2'd1;
				end
				if (emit) begin
					col_q <= col_after;
				end
			end
		end
	end

endmodule

[hw/rtl/bpu_queue.sv]
// Short command queue between front and back of the BMP pixel unpacker.
// Depends on bpu_pkg.
module bpu_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bpu_pkg::cmd_t     push_cmd,
	input  logic              pop,
	output logic              full,
	output logic              not_empty,
	output bpu_pkg::cmd_t     head
);
	import bpu_pkg::*;

	localparam int unsigned PW = $clog2(QUEUE_DEPTH);

	cmd_t            mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;

	assign full      = count_q == (PW+1)'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = mem_q[rd_ptr_q];

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/bpu_back.sv]
// Back end of the BMP pixel unpacker: palette memory, per-pixel index
// extraction, color keying and the output register. Depends on bpu_pkg.
module bpu_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  bpu_pkg::cmd_t     head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       pixel_argb,
	output logic              row_end,
	output logic              image_end,
	output logic              last
);
	import bpu_pkg::*;

	logic [23:0] pal_q [PAL_DEPTH];

	logic [2:0]  k_q;
	logic        valid_s2;
	logic        raw_s2;
	logic [23:0] raw_rgb_s2;
	logic [23:0] pal_rd_s2;
	logic        row_end_s2;
	logic        image_end_s2;
	logic        last_s2;
	logic        out_valid_q;
	logic [31:0] pixel_q;
	logic        row_end_q;
	logic        image_end_q;
	logic        last_q;

	logic        out_adv;
	logic        s2_adv;
	logic        issue;
	logic        last_pix;
	logic [4:0]  shw;
	logic [7:0]  shifted;
	logic [7:0]  idx;

	// Pipeline advance and index extraction, most significant bits first
	always_comb begin
		out_adv  = !out_valid_q || out_ready;
		s2_adv   = !valid_s2 || out_adv;
		issue    = head_valid && s2_adv;
		last_pix = ({1'b0, k_q} + 4'd1) >= head.npix;
		shw      = {2'b0, k_q} << head.dsel;
		shifted  = head.byte_val << shw[2:0];
		unique case (head.dsel)
			2'd0:    idx = {7'b0, shifted[7]};
			2'd1:    idx = {6'b0, shifted[7:6]};
			2'd2:    idx = {4'b0, shifted[7:4]};
			default: idx = shifted;
		endcase
		pop = issue && (head.kind != KIND_INDEX || last_pix);
	end

	// Palette memory: write on palette items, registered read on lookups
	always_ff @(posedge clk) begin
		if (issue && head.kind == KIND_WRITE) begin
			pal_q[head.byte_val] <= head.color;
		end
		if (issue && head.kind == KIND_INDEX) begin
			pal_rd_s2 <= pal_q[idx];
		end
	end

	// Hold pixel payload in stage two
	always_ff @(posedge clk) begin
		if (issue) begin
			raw_s2       <= head.kind == KIND_RAW;
			raw_rgb_s2   <= head.color;
			last_s2      <= head.kind == KIND_RAW || last_pix;
			row_end_s2   <= (head.kind == KIND_RAW || last_pix) && head.row_end;
			image_end_s2 <= (head.kind == KIND_RAW || last_pix) && head.image_end;
		end
	end

	// Step through pixels of a lookup item, track stage-two valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (issue && head.kind == KIND_INDEX) begin
				k_q <= last_pix ? 3'd0 : k_q + 3'd1;
			end
			if (s2_adv) begin
				valid_s2 <= issue && head.kind != KIND_WRITE;
			end
		end
	end

	// Output register: finish the pixel and hold it while stalled
	always_ff @(posedge clk) begin
		if (out_adv && valid_s2) begin
			pixel_q     <= finish_pixel(raw_s2 ? raw_rgb_s2 : pal_rd_s2);
			row_end_q   <= row_end_s2;
			image_end_q <= image_end_s2;
			last_q      <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s2;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_argb = pixel_q;
	assign row_end    = row_end_q;
	assign image_end  = image_end_q;
	assign last       = last_q;

endmodule

[hw/rtl/bmp_pixel_unpacker.sv]
// BMP pixel unpacker top level: configuration registers, front, queue, back.
// Depends on bpu_pkg, bpu_front, bpu_queue and bpu_back.
//
// Usage: set bits_per_pixel (index 0), image_width (1) and image_height (2)
// through the write port while idle. Send items on in_valid/in_ready: op 0
// writes palette_color into palette entry palette_index, op 1 delivers the
// next byte of the padded pixel array. Each pixel leaves on
// out_valid/out_ready as pixel_argb with row_end, image_end and last (final
// pixel caused by its item). Padding bytes and palette writes give no pixel.
// A pixel passes through the queue, stage two and the output register to out_valid.
// Throughput: one item per cycle for depths 8 to 32 while out_ready stays
// high; a byte of depth 1, 2 or 4 yields up to 8, 4 or 2 pixels, one per
// cycle, since the palette memory serves one lookup per cycle, so such
// bytes fill the four-entry queue and in_ready drops until the pixels drain.
// Reset clears the position counters, the queue and the output stage and
// loads depth 8, width 1, height 1; palette contents are undefined until
// written. When out_ready is low the output holds its pixel, the pipeline
// and queue absorb items, and in_ready falls once the queue is full.
module bmp_pixel_unpacker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [7:0]  palette_index,
	input  logic [23:0] palette_color,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] pixel_argb,
	output logic        row_end,
	output logic        image_end,
	output logic        last
);
	import bpu_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	cmd_t head;
	logic push;
	logic pop;
	logic full;
	logic not_empty;
	logic accept;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bits_per_pixel <= 6'd8;
			cfg_q.image_width    <= 13'd1;
			cfg_q.image_height   <= 13'd1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_BPP:    cfg_q.bits_per_pixel <= cfg_data[5:0];
				REG_WIDTH:  cfg_q.image_width    <= cfg_data;
				REG_HEIGHT: cfg_q.image_height   <= cfg_data;
				default:    cfg_q <= cfg_q;
			endcase
		end
	end

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	bpu_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.accept        (accept),
		.op            (op),
		.palette_index (palette_index),
		.palette_color (palette_color),
		.data_byte     (data_byte),
		.push          (push),
		.cmd           (cmd)
	);

	bpu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (cmd),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	bpu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (not_empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_argb (pixel_argb),
		.row_end    (row_end),
		.image_end  (image_end),
		.last       (last)
	);

endmodule
